FILE: rtl/core/table_atan2_octant_macros.svh
// Assertion macros shared by the atan2 RTL; clock and reset are taken from the using scope.
`ifndef TABLE_ATAN2_OCTANT_MACROS_SVH
`define TABLE_ATAN2_OCTANT_MACROS_SVH

// same-cycle implication
`define TAO_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TAO_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/tao_pkg.sv
// Types, constants and table-builder functions for the octant-folding atan2 block.
package tao_pkg;

   localparam int ANGLE_W = 16;
   localparam int ROM_W   = 13;

   localparam logic signed [ANGLE_W-1:0] ANG_ZERO = 16'sd0;
   localparam logic signed [ANGLE_W-1:0] ANG_PI2  = 16'sd12868;
   localparam logic signed [ANGLE_W-1:0] ANG_PI   = 16'sd25736;

   localparam logic [63:0] PI4_Q30 = 64'd843314857;
   localparam int          Q30_SH  = 30;
   localparam int          SERIES_TERMS = 28;

   typedef struct packed {
      logic                      sub;   // subtract table term from base
      logic                      zero;  // both magnitudes zero
      logic signed [ANGLE_W-1:0] base;
   } tao_ctrl_type;

   // shift-subtract division, elaboration only
   function automatic logic [63:0] tao_udiv(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] q;
      logic [63:0] r;
      q = '0;
      r = '0;
      for (int k = 63; k >= 0; k--) begin
         r = {r[62:0], num[k]};
         if (r >= den) begin
            r    = r - den;
            q[k] = 1'b1;
         end
      end
      return q;
   endfunction

   // alternating arctangent series in Q0.30, valid for u <= 0.5
   function automatic logic signed [63:0] tao_atan_series(input logic [63:0] u);
      logic [63:0]        u2;
      logic [63:0]        p;
      logic [63:0]        term;
      logic signed [63:0] sum;
      u2  = (u * u) >> Q30_SH;
      p   = u;
      sum = '0;
      for (int k = 0; k < SERIES_TERMS; k++) begin
         term = tao_udiv(p + 64'(k), 64'(2 * k + 1));
         if ((k & 1) != 0) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
         p = (p * u2) >> Q30_SH;
      end
      return sum;
   endfunction

   // atan(i/len) rounded into Q0.13
   function automatic logic [ROM_W-1:0] tao_atan_entry(input logic [63:0] i,
                                                       input logic [63:0] len);
      logic [63:0]        u;
      logic [63:0]        num;
      logic [63:0]        den;
      logic signed [63:0] a;
      if (i == 64'd0) begin
         return '0;
      end
      if ((i << 1) <= len) begin
         u = tao_udiv((i << Q30_SH) + (len >> 1), len);
         a = tao_atan_series(u);
      end else begin
         num = len - i;
         den = len + i;
         u   = tao_udiv((num << Q30_SH) + (den >> 1), den);
         a   = $signed(PI4_Q30) - tao_atan_series(u);
      end
      if (a < 0) begin
         a = '0;
      end
      return ROM_W'(($unsigned(a) + 64'h10000) >> 17);
   endfunction

endpackage

FILE: rtl/core/tao_if.sv
// Valid/ready stream interfaces for coordinate requests and angle responses.
interface tao_req_if #(
   parameter int COORD_BITS = 16
) ();
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] y_coord;
   logic signed [COORD_BITS-1:0] x_coord;

   modport source (output valid, output y_coord, output x_coord, input ready);
   modport sink   (input valid, input y_coord, input x_coord, output ready);
endinterface

interface tao_rsp_if
   import tao_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic signed [ANGLE_W-1:0] angle;

   modport source (output valid, output angle, input ready);
   modport sink   (input valid, input angle, output ready);
endinterface

FILE: rtl/core/tao_fold.sv
// Octant fold stage: magnitudes, min/max selection and base angle per octant.
module tao_fold
   import tao_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic                         in_valid,
   input  logic signed [COORD_BITS-1:0] in_y,
   input  logic signed [COORD_BITS-1:0] in_x,
   output logic                         out_valid,
   output logic [COORD_BITS-1:0]        out_a,
   output logic [COORD_BITS-1:0]        out_b,
   output tao_ctrl_type                 out_ctrl
);

   logic                  yneg;
   logic                  xneg;
   logic [COORD_BITS-1:0] ymag;
   logic [COORD_BITS-1:0] xmag;
   logic                  swap;
   logic [COORD_BITS-1:0] a_in;
   logic [COORD_BITS-1:0] b_in;
   tao_ctrl_type          ctrl_in;

   logic                  valid_ff;
   logic [COORD_BITS-1:0] a_ff;
   logic [COORD_BITS-1:0] b_ff;
   tao_ctrl_type          ctrl_ff;

   assign yneg = in_y[COORD_BITS-1];
   assign xneg = in_x[COORD_BITS-1];
   // most negative value maps to 2^(N-1), which still fits unsigned
   assign ymag = yneg ? (~$unsigned(in_y) + 1'b1) : $unsigned(in_y);
   assign xmag = xneg ? (~$unsigned(in_x) + 1'b1) : $unsigned(in_x);
   assign swap = (xmag < ymag);
   assign a_in = swap ? xmag : ymag;
   assign b_in = swap ? ymag : xmag;

   always_comb begin
      ctrl_in.zero = (b_in == '0);
      if (!yneg) begin
         if (!xneg) begin
            ctrl_in.base = swap ? ANG_PI2 : ANG_ZERO;
            ctrl_in.sub  = swap;
         end else begin
            ctrl_in.base = swap ? ANG_PI2 : ANG_PI;
            ctrl_in.sub  = !swap;
         end
      end else begin
         if (xneg) begin
            ctrl_in.base = swap ? -ANG_PI2 : -ANG_PI;
            ctrl_in.sub  = swap;
         end else begin
            ctrl_in.base = swap ? -ANG_PI2 : ANG_ZERO;
            ctrl_in.sub  = !swap;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_ff    <= a_in;
         b_ff    <= b_in;
         ctrl_ff <= ctrl_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_a     = a_ff;
   assign out_b     = b_ff;
   assign out_ctrl  = ctrl_ff;

endmodule

FILE: rtl/core/tao_div.sv
// Pipelined restoring divider: index = floor((2*L*a + b) / (2*b)), one quotient bit per stage.
module tao_div
   import tao_pkg::*;
#(
   parameter  int TABLE_LEN  = 1024,
   parameter  int COORD_BITS = 16,
   localparam int IDX_W      = $clog2(TABLE_LEN + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  logic [COORD_BITS-1:0] in_a,
   input  logic [COORD_BITS-1:0] in_b,
   input  tao_ctrl_type          in_ctrl,
   output logic                  out_valid,
   output logic [IDX_W-1:0]      out_quot,
   output tao_ctrl_type          out_ctrl
);

   localparam int REM_W = COORD_BITS + IDX_W + 1;
   localparam int DSR_W = COORD_BITS + 1;

   logic               valid_ff [IDX_W];
   logic [IDX_W-1:0]   quot_ff  [IDX_W];
   tao_ctrl_type       ctrl_ff  [IDX_W];
   // remainder and divisor are not needed after the last bit
   logic [REM_W-1:0]   rem_ff   [IDX_W-1];
   logic [DSR_W-1:0]   dsr_ff   [IDX_W-1];

   for (genvar gs = 0; gs < IDX_W; gs++) begin : g_stage
      localparam int BIT = IDX_W - 1 - gs;

      logic             valid_src;
      logic [REM_W-1:0] rem_src;
      logic [DSR_W-1:0] dsr_src;
      logic [IDX_W-1:0] quot_src;
      tao_ctrl_type     ctrl_src;
      logic [REM_W-1:0] sub_val;
      logic [REM_W-1:0] rem_in;
      logic [IDX_W-1:0] quot_in;

      if (gs == 0) begin : g_first
         assign valid_src = in_valid;
         assign rem_src   = REM_W'(in_a) * REM_W'(2 * TABLE_LEN) + REM_W'(in_b);
         assign dsr_src   = {in_b, 1'b0};
         assign quot_src  = '0;
         assign ctrl_src  = in_ctrl;
      end else begin : g_next
         assign valid_src = valid_ff[gs-1];
         assign rem_src   = rem_ff[gs-1];
         assign dsr_src   = dsr_ff[gs-1];
         assign quot_src  = quot_ff[gs-1];
         assign ctrl_src  = ctrl_ff[gs-1];
      end

      assign sub_val = REM_W'(dsr_src) << BIT;

      always_comb begin
         rem_in  = rem_src;
         quot_in = quot_src;
         if (rem_src >= sub_val) begin
            rem_in       = rem_src - sub_val;
            quot_in[BIT] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[gs] <= 1'b0;
         end else if (advance) begin
            valid_ff[gs] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            quot_ff[gs] <= quot_in;
            ctrl_ff[gs] <= ctrl_src;
         end
      end

      if (gs < IDX_W - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (advance) begin
               rem_ff[gs] <= rem_in;
               dsr_ff[gs] <= dsr_src;
            end
         end
      end
   end

   assign out_valid = valid_ff[IDX_W-1];
   assign out_quot  = quot_ff[IDX_W-1];
   assign out_ctrl  = ctrl_ff[IDX_W-1];

endmodule

FILE: rtl/core/tao_rom.sv
// Arctangent ROM stage with registered read, entries built at elaboration.
module tao_rom
   import tao_pkg::*;
#(
   parameter  int TABLE_LEN = 1024,
   localparam int IDX_W     = $clog2(TABLE_LEN + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             in_valid,
   input  logic [IDX_W-1:0] in_idx,
   input  tao_ctrl_type     in_ctrl,
   output logic             out_valid,
   output logic [ROM_W-1:0] out_data,
   output tao_ctrl_type     out_ctrl
);

   logic [ROM_W-1:0] rom_val [TABLE_LEN+1];
   logic [IDX_W-1:0] idx_clamp;

   logic             valid_ff;
   logic [ROM_W-1:0] data_ff;
   tao_ctrl_type     ctrl_ff;

   for (genvar gi = 0; gi <= TABLE_LEN; gi++) begin : g_rom
      localparam logic [ROM_W-1:0] ENTRY = tao_atan_entry(64'(gi), 64'(TABLE_LEN));
      assign rom_val[gi] = ENTRY;
   end

   // only a zero divisor overshoots; that word is forced to zero downstream
   assign idx_clamp = (in_idx > IDX_W'(TABLE_LEN)) ? IDX_W'(TABLE_LEN) : in_idx;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= rom_val[idx_clamp];
         ctrl_ff <= in_ctrl;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;
   assign out_ctrl  = ctrl_ff;

endmodule

FILE: rtl/core/table_atan2_octant.sv
// Path from accept to result: one fold stage, one divider stage per index bit,
// the ROM read, the output register.
// Throughput: one word per cycle; any stall on the response side freezes every stage.
// Reset clears all stage valid bits and the output valid; the ROM is constant
// and needs no initialization pass.
`include "table_atan2_octant_macros.svh"

module table_atan2_octant
   import tao_pkg::*;
#(
   parameter int TABLE_LEN  = 1024,
   parameter int COORD_BITS = 16
) (
   input logic      clock,
   input logic      reset,
   tao_req_if.sink  req_chan,
   tao_rsp_if.source rsp_chan
);

   localparam int IDX_W = $clog2(TABLE_LEN + 1);

   logic                      advance;

   logic                      fold_valid;
   logic [COORD_BITS-1:0]     fold_a;
   logic [COORD_BITS-1:0]     fold_b;
   tao_ctrl_type              fold_ctrl;

   logic                      div_valid;
   logic [IDX_W-1:0]          div_quot;
   tao_ctrl_type              div_ctrl;

   logic                      rom_valid;
   logic [ROM_W-1:0]          rom_data;
   tao_ctrl_type              rom_ctrl;

   logic [ANGLE_W-1:0]        term;
   logic signed [ANGLE_W-1:0] angle_in;
   logic                      rsp_valid_ff;
   logic signed [ANGLE_W-1:0] angle_ff;

   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = advance;

   tao_fold #(
      .COORD_BITS (COORD_BITS)
   ) u_fold (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_chan.valid),
      .in_y      (req_chan.y_coord),
      .in_x      (req_chan.x_coord),
      .out_valid (fold_valid),
      .out_a     (fold_a),
      .out_b     (fold_b),
      .out_ctrl  (fold_ctrl)
   );

   tao_div #(
      .TABLE_LEN  (TABLE_LEN),
      .COORD_BITS (COORD_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (fold_valid),
      .in_a      (fold_a),
      .in_b      (fold_b),
      .in_ctrl   (fold_ctrl),
      .out_valid (div_valid),
      .out_quot  (div_quot),
      .out_ctrl  (div_ctrl)
   );

   tao_rom #(
      .TABLE_LEN (TABLE_LEN)
   ) u_rom (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (div_valid),
      .in_idx    (div_quot),
      .in_ctrl   (div_ctrl),
      .out_valid (rom_valid),
      .out_data  (rom_data),
      .out_ctrl  (rom_ctrl)
   );

   assign term     = rom_ctrl.zero ? '0 : {{(ANGLE_W - ROM_W){1'b0}}, rom_data};
   assign angle_in = rom_ctrl.sub ? (rom_ctrl.base - $signed(term))
                                  : (rom_ctrl.base + $signed(term));

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rom_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         angle_ff <= angle_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.angle = angle_ff;

   `TAO_ASSERT_SAME(a_angle_range, rsp_valid_ff, (angle_ff >= -ANG_PI) && (angle_ff <= ANG_PI), "angle word out of range")
   `TAO_ASSERT_NEXT(a_enter_fold, req_chan.valid && req_chan.ready, fold_valid, "accepted word missing from fold stage")
   `TAO_ASSERT_NEXT(a_stall_hold, !advance, $stable(fold_valid) && $stable(div_valid) && $stable(rom_valid), "pipeline moved during stall")
   `TAO_ASSERT_SAME(a_no_accept_stalled, rsp_valid_ff && !rsp_chan.ready, !req_chan.ready, "word taken while output stalled")

endmodule

FILE: verif/table_atan2_octant_test.sv
// Self-checking testbench for the octant-folding atan2 block: directed corners, random pairs.
`timescale 1ns / 1ps

module table_atan2_octant_test;
   import tao_pkg::*;

   localparam int TABLE_LEN    = 1024;
   localparam int COORD_BITS   = 16;
   localparam int RANDOM_ITEMS = 1826;
   localparam int QUIET_ITEMS  = 300;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 40;

   typedef struct packed {
      logic signed [15:0] y_coord;
      logic signed [15:0] x_coord;
   } coord_pair_type;

   // Holds the arctangent table, predicts each angle and checks returned words in order.
   class atan2_angle_check;

      typedef struct {
         coord_pair_type                     coords;
         logic signed [tao_pkg::ANGLE_W-1:0] angle;
      } angle_expect_type;

      bit [tao_pkg::ROM_W-1:0] arctan_rom [TABLE_LEN+1];
      angle_expect_type        expected_angles [$];
      int                      noted;
      int                      checked;
      int                      fail_count;
      int                      diagonal_count;
      int                      axis_count;

      function new();
         for (int i = 0; i <= TABLE_LEN; i++) begin
            arctan_rom[i] = arctan_entry(64'(i));
         end
      endfunction

      // alternating series in Q0.30, argument at most one half
      function longint arctan_series(bit [63:0] u);
         bit [63:0] u_sq;
         bit [63:0] power;
         longint    term;
         longint    acc;
         u_sq  = (u * u) >> 30;
         power = u;
         acc   = 0;
         for (int k = 0; k < 28; k++) begin
            term = longint'((power + 64'(k)) / 64'(2 * k + 1));
            if ((k & 1) != 0) begin
               acc = acc - term;
            end else begin
               acc = acc + term;
            end
            power = (power * u_sq) >> 30;
         end
         return acc;
      endfunction

      function bit [tao_pkg::ROM_W-1:0] arctan_entry(bit [63:0] i);
         bit [63:0] len;
         bit [63:0] u;
         longint    a;
         len = 64'(TABLE_LEN);
         if (i == 0) begin
            return '0;
         end
         if (2 * i <= len) begin
            u = ((i << 30) + len / 2) / len;
            a = arctan_series(u);
         end else begin
            // reduce: atan(t) = pi/4 - atan((1-t)/(1+t))
            u = (((len - i) << 30) + (len + i) / 2) / (len + i);
            a = longint'(tao_pkg::PI4_Q30) - arctan_series(u);
         end
         if (a < 0) begin
            a = 0;
         end
         return tao_pkg::ROM_W'((64'(a) + 64'h10000) >> 17);
      endfunction

      // table term for minor <= major magnitude, index rounded half up
      function int table_term(int minor, int major);
         int idx;
         if (major == 0) begin
            return 0;
         end
         idx = (2 * TABLE_LEN * minor + major) / (2 * major);
         if (idx > TABLE_LEN) begin
            idx = TABLE_LEN;
         end
         return int'(arctan_rom[idx]);
      endfunction

      function logic signed [tao_pkg::ANGLE_W-1:0] fold_atan2(coord_pair_type c);
         int yv;
         int xv;
         int ym;
         int xm;
         int r;
         yv = c.y_coord;
         xv = c.x_coord;
         ym = (yv < 0) ? -yv : yv;
         xm = (xv < 0) ? -xv : xv;
         if (yv >= 0) begin
            if (xv >= 0) begin
               r = (xm >= ym) ? table_term(ym, xm) : tao_pkg::ANG_PI2 - table_term(xm, ym);
            end else begin
               r = (xm < ym) ? tao_pkg::ANG_PI2 + table_term(xm, ym)
                             : tao_pkg::ANG_PI - table_term(ym, xm);
            end
         end else begin
            if (xv < 0) begin
               r = (xm >= ym) ? -int'(tao_pkg::ANG_PI) + table_term(ym, xm)
                              : -int'(tao_pkg::ANG_PI2) - table_term(xm, ym);
            end else begin
               r = (xm < ym) ? -int'(tao_pkg::ANG_PI2) + table_term(xm, ym)
                             : -table_term(ym, xm);
            end
         end
         return tao_pkg::ANGLE_W'(r);
      endfunction

      function void note_coords(coord_pair_type c);
         angle_expect_type e;
         int               ym;
         int               xm;
         ym = (c.y_coord < 0) ? -int'(c.y_coord) : int'(c.y_coord);
         xm = (c.x_coord < 0) ? -int'(c.x_coord) : int'(c.x_coord);
         e.coords = c;
         e.angle  = fold_atan2(c);
         expected_angles.push_back(e);
         noted++;
         if (ym == xm) diagonal_count++;
         if (ym == 0 || xm == 0) axis_count++;
      endfunction

      function void check_angle(logic signed [tao_pkg::ANGLE_W-1:0] actual);
         angle_expect_type e;
         if (expected_angles.size() == 0) begin
            fail_count++;
            if (fail_count <= 200) $error("angle: expected none, actual %0d", actual);
            return;
         end
         e = expected_angles.pop_front();
         checked++;
         if (actual !== e.angle) begin
            fail_count++;
            if (fail_count <= 200) begin
               $error("angle: expected %0d, actual %0d (y %0d, x %0d)",
                      e.angle, actual, e.coords.y_coord, e.coords.x_coord);
            end
         end
      endfunction

      function int pending();
         return expected_angles.size();
      endfunction

   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   bit rsp_hold_req  = 1'b0;
   int req_idle_pct  = 0;
   int rsp_stall_pct = 0;
   int directed_sent = 0;

   atan2_angle_check angle_check = new();

   tao_req_if #(.COORD_BITS(COORD_BITS)) req_chan ();
   tao_rsp_if                            rsp_chan ();

   table_atan2_octant #(
      .TABLE_LEN  (TABLE_LEN),
      .COORD_BITS (COORD_BITS)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      reset <= 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

   // Offer one word and hold it until accepted; valid stays high for the next word.
   task automatic send_pair(coord_pair_type c);
      req_chan.valid   <= 1'b1;
      req_chan.y_coord <= c.y_coord;
      req_chan.x_coord <= c.x_coord;
      do @(posedge clock); while (!req_chan.ready);
      angle_check.note_coords(c);
   endtask

   task automatic idle_burst();
      req_chan.valid   <= 1'b0;
      req_chan.y_coord <= 16'($urandom);
      req_chan.x_coord <= 16'($urandom);
      repeat ($urandom_range(1, 12)) @(posedge clock);
   endtask

   function automatic logic signed [15:0] with_sign(int mag, bit neg);
      return 16'(neg ? -mag : mag);
   endfunction

   function automatic coord_pair_type make_pair(int y, int x);
      coord_pair_type c;
      c.y_coord = 16'(y);
      c.x_coord = 16'(x);
      return c;
   endfunction

   function automatic coord_pair_type random_pair();
      int             corner [7] = '{-32768, -32767, -1, 0, 1, 32766, 32767};
      int             pick;
      int             a;
      int             b;
      int             s;
      coord_pair_type c;
      logic signed [15:0] swap;
      pick = $urandom_range(99);
      if (pick < 35) begin
         c.y_coord = 16'($urandom);
         c.x_coord = 16'($urandom);
      end else begin
         if (pick < 55) begin
            a = $urandom_range(0, 40);
            b = $urandom_range(0, 40);
         end else if (pick < 70) begin
            // near the octant boundary |x| = |y|
            a = $urandom_range(0, 32767);
            b = a + $urandom_range(0, 4) - 2;
            if (b < 0) b = 0;
            if (b > 32767) b = 32767;
         end else if (pick < 80) begin
            a = 0;
            b = $urandom_range(0, 32768);
         end else if (pick < 90) begin
            // table index lands exactly on a half
            s = $urandom_range(11, 15);
            b = 1 << s;
            a = (2 * $urandom_range(0, 1023) + 1) << (s - 11);
         end else begin
            a = corner[$urandom_range(0, 6)];
            b = corner[$urandom_range(0, 6)];
         end
         c.y_coord = with_sign(a, $urandom_range(1));
         c.x_coord = with_sign(b, $urandom_range(1));
         if ($urandom_range(1)) begin
            swap      = c.y_coord;
            c.y_coord = c.x_coord;
            c.x_coord = swap;
         end
      end
      return c;
   endfunction

   // response side: random stalls, and one long hold-off on request
   initial begin
      int held;
      rsp_chan.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            rsp_chan.ready <= 1'b0;
            held = 0;
            while (held < HOLD_CYCLES) begin
               @(posedge clock);
               held++;
            end
         end else if (rsp_stall_pct != 0 && $urandom_range(99) < rsp_stall_pct) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end else begin
            rsp_chan.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         angle_check.check_angle(rsp_chan.angle);
      end
   end

   initial begin
      coord_pair_type directed [$];
      int             pct_choice [3];
      pct_choice       = '{0, 15, 40};
      req_chan.valid   <= 1'b0;
      req_chan.y_coord <= '0;
      req_chan.x_coord <= '0;

      // both zero, axes, corners, diagonals, seven of eight octants, half-way rounding
      directed = {make_pair(0, 0), make_pair(0, -5), make_pair(0, -32768),
                  make_pair(0, 32767), make_pair(32767, 0), make_pair(-32768, 0),
                  make_pair(-32768, -32768), make_pair(32767, 32767),
                  make_pair(-32768, 32767), make_pair(32767, -32768),
                  make_pair(1, -1), make_pair(-1, 1), make_pair(-1, -1), make_pair(1, 1),
                  make_pair(100, 99), make_pair(99, 100), make_pair(-100, 99),
                  make_pair(-99, -100), make_pair(1, 2048), make_pair(1, -2048),
                  make_pair(-2048, 1), make_pair(2, 3), make_pair(-32768, -32767),
                  make_pair(-32767, -32768)};

      do @(posedge clock); while (reset);

      foreach (directed[i]) begin
         send_pair(directed[i]);
         directed_sent++;
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 100 == 0) begin
            req_idle_pct  = pct_choice[$urandom_range(0, 2)];
            rsp_stall_pct = pct_choice[$urandom_range(0, 2)];
         end
         if (n >= RANDOM_ITEMS - QUIET_ITEMS) begin
            req_idle_pct  = 0;
            rsp_stall_pct = 0;
         end
         if (n == 150) begin
            rsp_hold_req = 1'b1;
         end
         if (req_idle_pct != 0 && $urandom_range(99) < req_idle_pct) begin
            idle_burst();
         end
         send_pair(random_pair());
      end
      req_chan.valid <= 1'b0;

      while (angle_check.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d coordinate pairs (%0d directed), %0d angles checked.",
               angle_check.noted, directed_sent, angle_check.checked);
      $display("Pairs on a diagonal: %0d, on an axis: %0d; one long output stall included.",
               angle_check.diagonal_count, angle_check.axis_count);
      if (angle_check.fail_count == 0 && angle_check.pending() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
